[hdl/cras_pkg.sv]
// ----------------------------------------------------------------------------
// Command ring allocator package
// Shared constants, operation and status codes, controller states and the
// packed transaction types of the input and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

package cras_pkg;

  // Default configuration of the ring and the command node table.
  localparam int unsigned RingBytesDef    = 8192;
  localparam int unsigned MaxNodesDef     = 64;
  localparam int unsigned AddrCmdBytesDef = 14;
  localparam int unsigned TxHdrBytesDef   = 16;

  // Fixed field widths.
  localparam int unsigned SizeW   = 15;  // largest slab is header plus 16383 bytes, rounded up to even
  localparam int unsigned OffOutW = 13;
  localparam int unsigned IdW     = 16;

  typedef enum logic [1:0] {
    OP_SETUP = 2'd0,
    OP_TX    = 2'd1,
    OP_DONE  = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_MEM    = 2'd2,
    ST_IDLE_DONE = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [1:0]     operation;
    logic [63:0]    station_addr;
    logic [15:0]    payload_len;
    logic [IdW-1:0] cmd_id;
    logic           cmd_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               start_valid;
    logic [OffOutW-1:0] start_offset;
    logic               done_valid;
    logic [IdW-1:0]     done_id;
    logic               done_ok;
  } out_item_t;

endpackage

`default_nettype wire

[hdl/cras_node_mem.sv]
// ----------------------------------------------------------------------------
// Command node table
// Single write port, single read port memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cras_node_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 43,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/cras_ctrl.sv]
// ----------------------------------------------------------------------------
// Command ring allocator controller
// Size check, slab placement in the ring, node allocation in submission
// order, and completion handling with a read of the next queued node.
// ----------------------------------------------------------------------------
`default_nettype none

module cras_ctrl #(
  parameter int unsigned RING_BYTES     = 8192,
  parameter int unsigned MAX_NODES      = 64,
  parameter int unsigned ADDR_CMD_BYTES = 14,
  parameter int unsigned TX_HDR_BYTES   = 16,
  parameter int unsigned RING_W         = $clog2(RING_BYTES + 1),
  parameter int unsigned OFF_W          = $clog2(RING_BYTES),
  parameter int unsigned NODE_W         = $clog2(MAX_NODES),
  parameter int unsigned ENTRY_W        = OFF_W + RING_W + 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire cras_pkg::in_item_t  in_data_i,
  input  wire logic                out_free_i,
  output      logic                res_valid_o,
  output      cras_pkg::out_item_t res_data_o,
  output      logic                mem_we_o,
  output      logic [NODE_W-1:0]   mem_waddr_o,
  output      logic [ENTRY_W-1:0]  mem_wdata_o,
  output      logic                mem_re_o,
  output      logic [NODE_W-1:0]   mem_raddr_o,
  input  wire logic [ENTRY_W-1:0]  mem_rdata_i
);

  import cras_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);
  localparam int unsigned SUM_W = ((RING_W > SizeW) ? RING_W : SizeW) + 1;
  localparam logic [SizeW-1:0]  AddrSize  = SizeW'(ADDR_CMD_BYTES + (ADDR_CMD_BYTES % 2));
  localparam logic [SizeW-1:0]  TxHdr     = SizeW'(TX_HDR_BYTES);
  localparam logic [SUM_W-1:0]  RingLimit = SUM_W'(RING_BYTES);
  localparam logic [RING_W-1:0] RingEnd   = RING_W'(RING_BYTES);
  localparam logic [NODE_W-1:0] LastNode  = NODE_W'(MAX_NODES - 1);
  localparam logic [CNT_W-1:0]  NodeCap   = CNT_W'(MAX_NODES);

  state_e              state_q, state_d;
  logic [RING_W-1:0]   head_q, head_d;
  logic [RING_W-1:0]   tail_q, tail_d;
  logic [NODE_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [NODE_W-1:0]   act_ptr_q, act_ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IdW-1:0]      act_id_q, act_id_d;
  logic [RING_W-1:0]   act_end_q, act_end_d;

  op_e                 req_op_q;
  logic                req_big_q;
  logic [SizeW-1:0]    req_size_q;
  logic [IdW-1:0]      req_id_q;
  logic                req_ok_q;

  logic                in_fire;
  logic                in_big;
  logic [SizeW-1:0]    in_size;
  logic [SizeW-1:0]    tx_raw;
  logic [SizeW-1:0]    tx_size;

  logic [SUM_W-1:0]    size_x;
  logic [SUM_W-1:0]    head_x;
  logic [SUM_W-1:0]    tail_sum;
  logic                place_ok;
  logic                place_zero;
  logic [RING_W-1:0]   alloc_off;
  logic [RING_W-1:0]   alloc_end;
  logic [OFF_W-1:0]    alloc_off_n;
  logic                node_free;
  logic [NODE_W-1:0]   next_act;
  logic [NODE_W-1:0]   next_wr;

  logic [OFF_W-1:0]    rd_off;
  logic [RING_W-1:0]   rd_end;
  logic [IdW-1:0]      rd_id;

  // Accept side: size check and slab size, the slab size rounded to even bytes.
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign tx_raw  = TxHdr + SizeW'(in_data_i.payload_len[13:0]);
  assign tx_size = tx_raw + {{(SizeW - 1){1'b0}}, tx_raw[0]};

  always_comb begin
    in_big  = 1'b0;
    in_size = AddrSize;
    unique case (in_data_i.operation)
      OP_SETUP: begin
        in_big  = |in_data_i.station_addr[63:48];
        in_size = AddrSize;
      end
      OP_TX: begin
        in_big  = |in_data_i.payload_len[15:14];
        in_size = tx_size;
      end
      default: begin
        in_big  = 1'b0;
        in_size = AddrSize;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_op_q   <= op_e'(in_data_i.operation);
      req_big_q  <= in_big;
      req_size_q <= in_size;
      req_id_q   <= in_data_i.cmd_id;
      req_ok_q   <= in_data_i.cmd_ok;
    end
  end

  // Node pointers advance with wrap at the table size.
  assign next_act = (act_ptr_q == LastNode) ? '0 : act_ptr_q + 1'b1;
  assign next_wr  = (wr_ptr_q == LastNode) ? '0 : wr_ptr_q + 1'b1;

  // A completion fetches the next queued node while the request settles.
  assign mem_re_o    = in_fire && (in_data_i.operation == OP_DONE);
  assign mem_raddr_o = next_act;
  assign {rd_off, rd_end, rd_id} = mem_rdata_i;

  // Slab placement.
  assign size_x   = SUM_W'(req_size_q);
  assign head_x   = SUM_W'(head_q);
  assign tail_sum = SUM_W'(tail_q) + size_x;

  always_comb begin
    place_ok   = 1'b0;
    place_zero = 1'b0;
    if (tail_q >= head_q) begin
      priority if (tail_sum <= RingLimit) begin
        place_ok = 1'b1;
      end else if (size_x < head_x) begin
        place_ok   = 1'b1;
        place_zero = 1'b1;
      end else begin
        place_ok = 1'b0;
      end
    end else begin
      place_ok = (tail_sum < head_x);
    end
  end

  assign alloc_off   = place_zero ? '0 : tail_q;
  assign alloc_end   = place_zero ? RING_W'(req_size_q) : RING_W'(tail_sum);
  assign alloc_off_n = OFF_W'(alloc_off);
  assign node_free   = (cnt_q != NodeCap);

  assign mem_waddr_o = wr_ptr_q;
  assign mem_wdata_o = {alloc_off_n, alloc_end, req_id_q};

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    wr_ptr_d    = wr_ptr_q;
    act_ptr_d   = act_ptr_q;
    cnt_d       = cnt_q;
    act_id_d    = act_id_q;
    act_end_d   = act_end_q;
    res_valid_o = 1'b0;
    res_data_o  = '0;
    mem_we_o    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
          unique case (req_op_q)
            OP_SETUP, OP_TX: begin
              priority if (req_big_q) begin
                res_data_o.status = ST_TOO_LARGE;
              end else if (!place_ok || !node_free) begin
                res_data_o.status = ST_NO_MEM;
              end else begin
                res_data_o.status = ST_OK;
                mem_we_o          = 1'b1;
                tail_d            = alloc_end;
                wr_ptr_d          = next_wr;
                cnt_d             = cnt_q + 1'b1;
                if (cnt_q == '0) begin
                  // Unit idle: the new command starts at once.
                  act_ptr_d               = wr_ptr_q;
                  act_id_d                = req_id_q;
                  act_end_d               = alloc_end;
                  res_data_o.start_valid  = 1'b1;
                  res_data_o.start_offset = OffOutW'(alloc_off_n);
                end
              end
            end
            OP_DONE: begin
              if (cnt_q == '0) begin
                res_data_o.status = ST_IDLE_DONE;
              end else begin
                res_data_o.status     = ST_OK;
                res_data_o.done_valid = 1'b1;
                res_data_o.done_id    = act_id_q;
                res_data_o.done_ok    = req_ok_q;
                cnt_d                 = cnt_q - 1'b1;
                act_ptr_d             = next_act;
                if (cnt_q == CNT_W'(1)) begin
                  // Ring empties: the free point becomes the whole ring.
                  head_d = tail_q;
                end else begin
                  head_d                  = (act_end_q == RingEnd) ? '0 : act_end_q;
                  act_id_d                = rd_id;
                  act_end_d               = rd_end;
                  res_data_o.start_valid  = 1'b1;
                  res_data_o.start_offset = OffOutW'(rd_off);
                end
              end
            end
            OP_RSVD: begin
              res_data_o = '0;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      wr_ptr_q  <= '0;
      act_ptr_q <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      wr_ptr_q  <= wr_ptr_d;
      act_ptr_q <= act_ptr_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_id_q  <= act_id_d;
    act_end_q <= act_end_d;
  end

`ifndef SYNTH
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NodeCap)
    else $error("node count exceeds table size");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (act_ptr_q == wr_ptr_q))
    else $error("active and write pointers differ with no node in use");

  a_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("node table read and write in the same cycle");

  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (out_free_i && (state_q == S_EXEC)))
    else $error("result produced without a free output slot");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q <= RingEnd) && (head_q <= RingEnd))
    else $error("ring pointer beyond the ring end");
`endif

endmodule

`default_nettype wire

[hdl/command_ring_allocator_scheduler_top.sv]
// Path: a transaction is accepted in the idle state, its result is formed in the
// execute state once the output slot is free, and is then registered at the output.
// Flow: a new transaction is taken only in the idle state, after the previous
// one has left the execute state with its result, so transactions do not overlap.
// Reset: asynchronous, active low; it empties the ring and the node queue.
// ----------------------------------------------------------------------------
// Command ring allocator and scheduler
// Hands out even-sized slabs of a byte ring to submitted commands, keeps the
// commands in a node table in submission order and starts them one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module command_ring_allocator_scheduler_top #(
  parameter int unsigned RING_BYTES     = cras_pkg::RingBytesDef,
  parameter int unsigned MAX_NODES      = cras_pkg::MaxNodesDef,
  parameter int unsigned ADDR_CMD_BYTES = cras_pkg::AddrCmdBytesDef,
  parameter int unsigned TX_HDR_BYTES   = cras_pkg::TxHdrBytesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire cras_pkg::in_item_t  in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      cras_pkg::out_item_t out_data_o
);

  import cras_pkg::*;

  // Ring pointers must hold the ring size itself; offsets stay below it.
  localparam int unsigned RING_W  = $clog2(RING_BYTES + 1);
  localparam int unsigned OFF_W   = $clog2(RING_BYTES);
  localparam int unsigned NODE_W  = $clog2(MAX_NODES);
  // Each node keeps the slab offset, the slab end and the command id.
  localparam int unsigned ENTRY_W = OFF_W + RING_W + IdW;

  logic               res_valid;
  out_item_t          res_data;
  logic               out_free;
  logic               out_valid_q;
  out_item_t          out_data_q;

  logic               mem_we;
  logic [NODE_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [NODE_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  // The output register frees the controller: it may take the next
  // transaction while a result still waits here, and only holds its own
  // result back until this slot is free.
  assign out_free = !out_valid_q || out_ready_i;

  cras_ctrl #(
    .RING_BYTES    (RING_BYTES),
    .MAX_NODES     (MAX_NODES),
    .ADDR_CMD_BYTES(ADDR_CMD_BYTES),
    .TX_HDR_BYTES  (TX_HDR_BYTES),
    .RING_W        (RING_W),
    .OFF_W         (OFF_W),
    .NODE_W        (NODE_W),
    .ENTRY_W       (ENTRY_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // The node table is written when a slab is allocated and read at each completion for the
  // node that follows the active one; the read data is used only when such a node is queued.
  cras_node_mem #(
    .DEPTH (MAX_NODES),
    .DATA_W(ENTRY_W),
    .ADDR_W(NODE_W)
  ) u_node_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  // Result payload is loaded only with a new result, so it holds while stalled.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire
